@@ hw/rtl/scom_pkg.sv @@
// scom_pkg: shared widths, constants, register indexes and struct types
// for the scan curvature and occlusion marker; no dependencies
`default_nettype none

package scom_pkg;

  localparam int RANGE_W = 18;
  localparam int COL_W = 12;
  localparam int IDX_W = 16;
  localparam int CURV_W = 43;
  localparam int THR_W = 16;
  localparam int RATIO_W = 16;

  // sliding window
  localparam int DEPTH = 12;
  localparam int SLOT_W = 4;
  localparam int HELD_W = 4;

  // running sums and signed tap sum
  localparam int SUM_W = 23;
  localparam int S_W = 23;
  localparam int MAG_W = 22;
  localparam int PROD_W = RANGE_W + RATIO_W;

  localparam int MAX_POINTS_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_RATIO_SPIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_RATIO_SOLID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_GAP = 3'd4;

  localparam logic [THR_W-1:0] OCC_THRESHOLD_RST = 16'd300;
  localparam logic [RATIO_W-1:0] BEAM_RATIO_SPIN_RST = 16'd1311;
  localparam logic [RATIO_W-1:0] BEAM_RATIO_SOLID_RST = 16'd6554;
  localparam logic [COL_W-1:0] COLUMN_GAP_RST = 12'd10;

  typedef struct packed {
    logic               sensor_mode;
    logic [THR_W-1:0]   occlusion_threshold_mm;
    logic [RATIO_W-1:0] beam_ratio_spin_q16;
    logic [RATIO_W-1:0] beam_ratio_solid_q16;
    logic [COL_W-1:0]   column_gap_limit;
  } cfg_t;

  // one queued result, curvature still as signed tap sum
  typedef struct packed {
    logic [IDX_W-1:0]  point_index;
    logic signed [S_W-1:0] tap_sum;
    logic              interior;
    logic              picked;
    logic              last_result;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/scom_in_if.sv @@
// scom_in_if: point input channel, valid/ready with point payload
// depends on scom_pkg
`default_nettype none

interface scom_in_if;
  import scom_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic [COL_W-1:0]   column;
  logic               last_point;

  modport source (output valid, range_mm, column, last_point, input ready);
  modport sink (input valid, range_mm, column, last_point, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scom_out_if.sv @@
// scom_out_if: result output channel, valid/ready with result payload
// depends on scom_pkg
`default_nettype none

interface scom_out_if;
  import scom_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  point_index;
  logic [CURV_W-1:0] curvature;
  logic              interior;
  logic              picked;
  logic              last_result;

  modport source (output valid, point_index, curvature, interior, picked, last_result,
                  input ready);
  modport sink (input valid, point_index, curvature, interior, picked, last_result,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scom_queue.sv @@
// scom_queue: small register queue of result entries between front and back
// depends on scom_pkg
`default_nettype none

module scom_queue #(
  parameter int unsigned Q_DEPTH = scom_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scom_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output scom_pkg::entry_t head
);
  import scom_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  entry_t             mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scom_front.sv @@
// scom_front: accepts points, keeps the 12-point window, tap sums and marks,
// and hands finished entries to the queue; depends on scom_pkg, scom_in_if
`default_nettype none

module scom_front #(
  parameter int unsigned MAX_POINTS = scom_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  scom_in_if.sink          point_ch,
  input  scom_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output scom_pkg::entry_t push_entry
);
  import scom_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS);
  localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(DEPTH);
  localparam logic [HELD_W-1:0] HELD_INNER = HELD_W'(DEPTH - 1);

  logic [RANGE_W-1:0]    range_w [DEPTH];
  logic [COL_W-1:0]      col_w [DEPTH];
  logic [IDX_W-1:0]      idx_w [DEPTH];
  logic signed [S_W-1:0] s_w [DEPTH];
  logic                  inner_w [DEPTH];
  logic                  mark_w [DEPTH];
  logic [SUM_W-1:0]      sum11;
  logic [SUM_W-1:0]      sum5;
  logic [HELD_W-1:0]     held;
  logic [CNT_W-1:0]      cnt;
  logic                  flushing;
  logic [SLOT_W-1:0]     flush_ptr;

  logic [RANGE_W-1:0]    range_next [DEPTH];
  logic [COL_W-1:0]      col_next [DEPTH];
  logic [IDX_W-1:0]      idx_next [DEPTH];
  logic signed [S_W-1:0] s_next [DEPTH];
  logic                  inner_next [DEPTH];
  logic                  mark_next [DEPTH];
  logic [SUM_W-1:0]      sum11_next;
  logic [SUM_W-1:0]      sum5_next;
  logic [HELD_W-1:0]     held_next;

  logic                  fire;
  logic                  flush_step;
  logic                  clear;
  logic                  solid;
  logic [SUM_W-1:0]      ctr;
  logic [SUM_W-1:0]      tap_sel;
  logic [RANGE_W-1:0]    r0;
  logic [RANGE_W-1:0]    r1;
  logic [RANGE_W-1:0]    r7;
  logic [COL_W-1:0]      cdiff;
  logic                  adjacent;
  logic                  occ_down;
  logic                  occ_up;
  logic [RANGE_W-1:0]    thr;
  logic [RATIO_W-1:0]    ratio;
  logic [PROD_W-1:0]     lim;
  logic [RANGE_W-1:0]    d_prev;
  logic [RANGE_W-1:0]    d_next;

  assign point_ch.ready = !flushing && !q_full;
  assign fire = point_ch.valid && point_ch.ready;
  assign flush_step = flushing && !q_full;
  assign clear = rst || (flush_step && (flush_ptr == '0));
  assign solid = cfg.sensor_mode;

  always_comb begin
    range_next[0] = point_ch.range_mm;
    col_next[0] = point_ch.column;
    idx_next[0] = IDX_W'(cnt);
    s_next[0] = '0;
    inner_next[0] = 1'b0;
    mark_next[0] = 1'b0;
    for (int k = 1; k < DEPTH; k++) begin
      range_next[k] = range_w[k-1];
      col_next[k] = col_w[k-1];
      idx_next[k] = idx_w[k-1];
      s_next[k] = s_w[k-1];
      inner_next[k] = inner_w[k-1];
      mark_next[k] = mark_w[k-1];
    end

    held_next = (held == HELD_FULL) ? held : held + 1'b1;

    // running sums over slots 0..10 and 3..7 of the shifted window
    sum11_next = sum11 + SUM_W'(point_ch.range_mm) - SUM_W'(range_w[10]);
    sum5_next = sum5 + SUM_W'(range_w[2]) - SUM_W'(range_w[7]);

    // centre point lands in slot 5
    ctr = SUM_W'(range_w[4]);
    if (solid) begin
      tap_sel = sum5_next - ((ctr << 2) + ctr);
    end else begin
      tap_sel = sum11_next - ((ctr << 3) + (ctr << 1) + ctr);
    end
    if (held_next >= HELD_INNER) begin
      s_next[5] = $signed(tap_sel);
      inner_next[5] = 1'b1;
    end

    // marking rule for shifted slot 6
    r0 = range_w[5];
    r1 = range_w[4];
    r7 = range_w[6];
    cdiff = (col_w[4] > col_w[5]) ? col_w[4] - col_w[5] : col_w[5] - col_w[4];
    adjacent = cdiff < cfg.column_gap_limit;
    thr = RANGE_W'(cfg.occlusion_threshold_mm);
    occ_down = (r0 > r1) && ((r0 - r1) > thr);
    occ_up = (r1 > r0) && ((r1 - r0) > thr);
    ratio = solid ? cfg.beam_ratio_solid_q16 : cfg.beam_ratio_spin_q16;
    lim = PROD_W'(ratio) * PROD_W'(r0);
    d_prev = (r7 > r0) ? r7 - r0 : r0 - r7;
    d_next = (r1 > r0) ? r1 - r0 : r0 - r1;

    if (held_next == HELD_FULL) begin
      if (adjacent) begin
        if (occ_down) begin
          for (int k = 6; k < DEPTH; k++) begin
            if (k <= 7 || !solid) mark_next[k] = 1'b1;
          end
        end else if (occ_up) begin
          for (int k = 0; k <= 5; k++) begin
            if (k >= 4 || !solid) mark_next[k] = 1'b1;
          end
        end
      end
      if (({d_prev, 16'h0} > lim) && ({d_next, 16'h0} > lim)) begin
        mark_next[6] = 1'b1;
      end
    end
  end

  always_comb begin
    if (flushing) begin
      push = !q_full;
      push_entry.point_index = idx_w[flush_ptr];
      push_entry.tap_sum = s_w[flush_ptr];
      push_entry.interior = inner_w[flush_ptr];
      push_entry.picked = mark_w[flush_ptr];
      push_entry.last_result = (flush_ptr == '0);
    end else begin
      push = fire && !point_ch.last_point && (held_next == HELD_FULL);
      push_entry.point_index = idx_next[DEPTH-1];
      push_entry.tap_sum = s_next[DEPTH-1];
      push_entry.interior = inner_next[DEPTH-1];
      push_entry.picked = mark_next[DEPTH-1];
      push_entry.last_result = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      range_w <= '{default: '0};
      col_w <= '{default: '0};
      idx_w <= '{default: '0};
      s_w <= '{default: '0};
      inner_w <= '{default: 1'b0};
      mark_w <= '{default: 1'b0};
      sum11 <= '0;
      sum5 <= '0;
      held <= '0;
      cnt <= '0;
      flushing <= 1'b0;
      flush_ptr <= '0;
    end else if (fire) begin
      range_w <= range_next;
      col_w <= col_next;
      idx_w <= idx_next;
      s_w <= s_next;
      inner_w <= inner_next;
      mark_w <= mark_next;
      sum11 <= sum11_next;
      sum5 <= sum5_next;
      held <= held_next;
      cnt <= (cnt == CNT_W'(MAX_POINTS - 1)) ? '0 : cnt + 1'b1;
      if (point_ch.last_point) begin
        flushing <= 1'b1;
        flush_ptr <= SLOT_W'(held_next - 1'b1);
      end
    end else if (flush_step) begin
      flush_ptr <= flush_ptr - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scom_back.sv @@
// scom_back: takes queued entries, forms |tap sum| then its square,
// and drives the result channel; depends on scom_pkg, scom_out_if
`default_nettype none

module scom_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  scom_pkg::entry_t head,
  output logic             pop,
  scom_out_if.source       result_ch
);
  import scom_pkg::*;

  logic                 v1;
  logic                 v2;
  logic                 en1;
  logic                 en2;
  logic [MAG_W-1:0]     mag_in;
  logic [MAG_W-1:0]     mag1;
  logic [2*MAG_W-1:0]   sq;
  logic [IDX_W-1:0]     idx1;
  logic                 inner1;
  logic                 picked1;
  logic                 last1;
  logic [IDX_W-1:0]     idx2;
  logic [CURV_W-1:0]    curv2;
  logic                 inner2;
  logic                 picked2;
  logic                 last2;

  assign en2 = !v2 || result_ch.ready;
  assign en1 = !v1 || en2;
  assign pop = q_valid && en1;

  assign mag_in = head.tap_sum[S_W-1] ? MAG_W'(-head.tap_sum) : MAG_W'(head.tap_sum);
  assign sq = mag1 * mag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= q_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && q_valid) begin
      mag1 <= mag_in;
      idx1 <= head.point_index;
      inner1 <= head.interior;
      picked1 <= head.picked;
      last1 <= head.last_result;
    end
    if (en2 && v1) begin
      curv2 <= sq[CURV_W-1:0];
      idx2 <= idx1;
      inner2 <= inner1;
      picked2 <= picked1;
      last2 <= last1;
    end
  end

  assign result_ch.valid = v2;
  assign result_ch.point_index = idx2;
  assign result_ch.curvature = curv2;
  assign result_ch.interior = inner2;
  assign result_ch.picked = picked2;
  assign result_ch.last_result = last2;

endmodule

`default_nettype wire

@@ hw/rtl/scan_curvature_occlusion_marker.sv @@
// scan curvature and occlusion marker, top level; uses scom_pkg, scom_in_if,
// scom_out_if, scom_front, scom_queue, scom_back
// throughput: one point word per cycle unless the queue is full; a point with
//   last_point set is followed by a flush of the held points (up to 12), one per
//   cycle unless the queue is full, from the window's single read port, while the
//   input is stalled; results pass the queue, the magnitude and output registers
// reset: synchronous, clears scan state, queue and pipeline, config to defaults
`default_nettype none

module scan_curvature_occlusion_marker #(
  parameter int unsigned MAX_POINTS = scom_pkg::MAX_POINTS_DEF,
  parameter int unsigned Q_DEPTH = scom_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  scom_in_if.sink                        point_ch,
  scom_out_if.source                     result_ch,
  input  logic                           cfg_we,
  input  logic [scom_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scom_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import scom_pkg::*;

  // configuration registers; the user writes them only while the block is idle, the block does not enforce it
  cfg_t   cfg;

  // front to queue
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // queue to back
  logic   q_valid;
  logic   pop;
  entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_mode <= 1'b0;
      cfg.occlusion_threshold_mm <= OCC_THRESHOLD_RST;
      cfg.beam_ratio_spin_q16 <= BEAM_RATIO_SPIN_RST;
      cfg.beam_ratio_solid_q16 <= BEAM_RATIO_SOLID_RST;
      cfg.column_gap_limit <= COLUMN_GAP_RST;
    end else if (cfg_we) begin
      // indexes past the register list are dropped
      unique case (cfg_index)
        REG_SENSOR_MODE:      cfg.sensor_mode <= cfg_wdata[0];
        REG_OCC_THRESHOLD:    cfg.occlusion_threshold_mm <= cfg_wdata[THR_W-1:0];
        REG_BEAM_RATIO_SPIN:  cfg.beam_ratio_spin_q16 <= cfg_wdata[RATIO_W-1:0];
        REG_BEAM_RATIO_SOLID: cfg.beam_ratio_solid_q16 <= cfg_wdata[RATIO_W-1:0];
        REG_COLUMN_GAP:       cfg.column_gap_limit <= cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // front: window shift, tap sums for the slot-5 point, marks from the
  // slot-6 point, emits the slot-11 point or runs the end-of-scan flush
  scom_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .point_ch   (point_ch),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue so front and back stall independently
  scom_queue #(
    .Q_DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  // back: magnitude then square, last stage is the output register
  scom_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_scan_curvature_occlusion_marker.sv @@
// testbench for the scan curvature and occlusion marker: drives point words,
// predicts every result word and checks it field by field
// depends on scom_pkg, scom_in_if, scom_out_if and the block itself
`default_nettype none

module tb_scan_curvature_occlusion_marker;
  timeunit 1ns;
  timeprecision 1ps;

  import scom_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT = 26;
  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_POINTS = 190;
  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam int RANGE_MAX = (1 << RANGE_W) - 1;
  localparam int COL_MAX = (1 << COL_W) - 1;
  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_LO = 3'd5;

  typedef struct {
    logic [IDX_W-1:0]  point_index;
    logic [CURV_W-1:0] curvature;
    logic              interior;
    logic              picked;
    logic              last_result;
  } scan_result_t;

  // window predictor plus the store of result words still to come
  class point_mark_tracker;
    logic                solid_mode;
    logic [THR_W-1:0]    occ_thr;
    logic [RATIO_W-1:0]  ratio_spin;
    logic [RATIO_W-1:0]  ratio_solid;
    logic [COL_W-1:0]    col_gap;

    logic [RANGE_W-1:0]  rng_win[DEPTH];
    logic [COL_W-1:0]    col_win[DEPTH];
    logic                mark_win[DEPTH];
    logic [CURV_W-1:0]   curv_win[DEPTH];
    logic                inner_win[DEPTH];
    logic [IDX_W-1:0]    idx_win[DEPTH];
    int                  next_index;
    int                  held;

    scan_result_t        due_results[$];
    int                  errors;

    function new();
      solid_mode = 1'b0;
      occ_thr = OCC_THRESHOLD_RST;
      ratio_spin = BEAM_RATIO_SPIN_RST;
      ratio_solid = BEAM_RATIO_SOLID_RST;
      col_gap = COLUMN_GAP_RST;
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      for (int k = 0; k < DEPTH; k++) begin
        rng_win[k] = '0;
        col_win[k] = '0;
        mark_win[k] = 1'b0;
        curv_win[k] = '0;
        inner_win[k] = 1'b0;
        idx_win[k] = '0;
      end
      next_index = 0;
      held = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SENSOR_MODE: solid_mode = data[0];
        REG_OCC_THRESHOLD: occ_thr = data[THR_W-1:0];
        REG_BEAM_RATIO_SPIN: ratio_spin = data[RATIO_W-1:0];
        REG_BEAM_RATIO_SOLID: ratio_solid = data[RATIO_W-1:0];
        REG_COLUMN_GAP: col_gap = data[COL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned gap_of(int unsigned a, int unsigned b);
      return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function void emit(int slot, logic last);
      scan_result_t res;
      res.point_index = idx_win[slot];
      res.curvature = curv_win[slot];
      res.interior = inner_win[slot];
      res.picked = mark_win[slot];
      res.last_result = last;
      due_results.insert(due_results.size(), res);
    endfunction

    // one accepted point word: shift, curvature, marking rule, emitted words
    function void take_point(logic [RANGE_W-1:0] r, logic [COL_W-1:0] c, logic last);
      longint tap;
      longint unsigned mag;
      longint unsigned lim;
      logic [RANGE_W-1:0] r0;
      logic [RANGE_W-1:0] r1;
      for (int k = DEPTH - 1; k > 0; k--) begin
        rng_win[k] = rng_win[k-1];
        col_win[k] = col_win[k-1];
        mark_win[k] = mark_win[k-1];
        curv_win[k] = curv_win[k-1];
        inner_win[k] = inner_win[k-1];
        idx_win[k] = idx_win[k-1];
      end
      rng_win[0] = r;
      col_win[0] = c;
      mark_win[0] = 1'b0;
      curv_win[0] = '0;
      inner_win[0] = 1'b0;
      idx_win[0] = IDX_W'(next_index);
      next_index = (next_index + 1 >= MAX_PTS) ? 0 : next_index + 1;
      if (held < DEPTH) held++;

      // curvature of the point five back
      if (held >= DEPTH - 1) begin
        if (solid_mode) begin
          tap = longint'(rng_win[3]) + longint'(rng_win[4]) + longint'(rng_win[6])
                + longint'(rng_win[7]) - 4 * longint'(rng_win[5]);
        end else begin
          tap = -10 * longint'(rng_win[5]);
          for (int k = 0; k <= 10; k++)
            if (k != 5) tap += longint'(rng_win[k]);
        end
        mag = (tap < 0) ? $unsigned(-tap) : $unsigned(tap);
        curv_win[5] = CURV_W'(mag * mag);
        inner_win[5] = 1'b1;
      end

      // occlusion and parallel beam rule for the point six back
      if (held >= DEPTH) begin
        r0 = rng_win[6];
        r1 = rng_win[5];
        lim = 64'(solid_mode ? ratio_solid : ratio_spin) * 64'(r0);
        if (gap_of(col_win[5], col_win[6]) < 64'(col_gap)) begin
          if (r0 > r1 && r0 - r1 > occ_thr) begin
            for (int k = 6; k <= (solid_mode ? 7 : 11); k++) mark_win[k] = 1'b1;
          end else if (r1 > r0 && r1 - r0 > occ_thr) begin
            for (int k = (solid_mode ? 4 : 0); k <= 5; k++) mark_win[k] = 1'b1;
          end
        end
        if ((gap_of(rng_win[7], r0) << 16) > lim && (gap_of(r1, r0) << 16) > lim)
          mark_win[6] = 1'b1;
      end

      if (!last) begin
        if (held >= DEPTH) emit(DEPTH - 1, 1'b0);
      end else begin
        for (int k = held - 1; k >= 0; k--) emit(k, k == 0);
        clear_scan();
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task match_result(logic [IDX_W-1:0] idx, logic [CURV_W-1:0] curv, logic inner,
                      logic pick, logic last);
      scan_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result word, point_index %0d", idx));
        return;
      end
      want = due_results.pop_front();
      if (idx !== want.point_index)
        report($sformatf("point_index %0d, want %0d", idx, want.point_index));
      if (curv !== want.curvature)
        report($sformatf("point %0d curvature %0d, want %0d", want.point_index, curv,
                         want.curvature));
      if (inner !== want.interior)
        report($sformatf("point %0d interior %b, want %b", want.point_index, inner,
                         want.interior));
      if (pick !== want.picked)
        report($sformatf("point %0d picked %b, want %b", want.point_index, pick,
                         want.picked));
      if (last !== want.last_result)
        report($sformatf("point %0d last_result %b, want %b", want.point_index, last,
                         want.last_result));
    endtask

    task close_out();
      if (due_results.size() != 0)
        report($sformatf("%0d result words never arrived", due_results.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  scom_in_if point_ch ();
  scom_out_if result_ch ();

  point_mark_tracker tracker;

  // idling switches and the receiver hold-off request, written by the main flow only
  bit send_idle;
  bit recv_idle;
  int hold_requests;
  int points_sent;
  int quiet_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  scan_curvature_occlusion_marker u_dut (
    .clk(clk),
    .rst(rst),
    .point_ch(point_ch),
    .result_ch(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // offer one point word, with random gaps ahead of it, until it is taken
  task automatic send_point(logic [RANGE_W-1:0] r, logic [COL_W-1:0] c, logic last);
    while (send_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
    end
    point_ch.valid <= 1'b1;
    point_ch.range_mm <= r;
    point_ch.column <= c;
    point_ch.last_point <= last;
    // ready is read right after the edge, so it is the value the edge saw
    do @(posedge clk); while (!point_ch.ready);
    tracker.take_point(r, c, last);
    points_sent++;
  endtask

  // stop offering, wait for every expected word, then let the pipe drain
  task automatic settle_block();
    point_ch.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // the caller lowers cfg_we after the last write of a batch
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // corner 1: loosest marking settings, corner 2: no occlusion marks, else random
  task automatic set_config(int corner);
    logic [THR_W-1:0] thr;
    logic [RATIO_W-1:0] rs;
    logic [RATIO_W-1:0] rso;
    logic [COL_W-1:0] gap;
    case (corner)
      1: begin
        thr = '0;
        gap = COL_W'(COL_MAX);
        rs = '0;
        rso = '0;
      end
      2: begin
        thr = '1;
        gap = '0;
        rs = '1;
        rso = '1;
      end
      default: begin
        thr = ($urandom_range(0, 9) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, 3000));
        gap = ($urandom_range(0, 9) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(0, 24));
        rs = ($urandom_range(0, 9) == 0) ? RATIO_W'($urandom)
                                         : RATIO_W'($urandom_range(0, 12000));
        rso = ($urandom_range(0, 9) == 0) ? RATIO_W'($urandom)
                                          : RATIO_W'($urandom_range(0, 12000));
      end
    endcase
    // upper data bits are noise that the block has to drop
    write_reg(REG_SENSOR_MODE, {15'($urandom), 1'($urandom)});
    write_reg(REG_OCC_THRESHOLD, thr);
    write_reg(REG_BEAM_RATIO_SPIN, rs);
    write_reg(REG_BEAM_RATIO_SOLID, rso);
    write_reg(REG_COLUMN_GAP, {4'($urandom), gap});
    write_reg(UNUSED_REG_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // one scan: smooth surface with jumps, spikes and column breaks, or pure noise
  task automatic run_scan(int len, bit noisy);
    int cur;
    int pick;
    int val;
    logic [COL_W-1:0] c;
    cur = $urandom_range(0, RANGE_MAX);
    c = COL_W'($urandom);
    for (int k = 0; k < len; k++) begin
      if (noisy) begin
        val = $urandom_range(0, RANGE_MAX);
        c = COL_W'($urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) cur = cur + int'($urandom_range(0, 100)) - 50;
        else if (pick < 76)
          cur = cur + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(100, 30000));
        else if (pick < 93 && pick >= 86) cur = $urandom_range(0, 1) ? 0 : RANGE_MAX;
        else if (pick >= 93) cur = $urandom_range(0, RANGE_MAX);
        if (cur < 0) cur = 0;
        if (cur > RANGE_MAX) cur = RANGE_MAX;
        val = cur;
        // single-point spike, the surface itself does not move
        if (pick >= 76 && pick < 86)
          val = cur + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2000, 50000));
        if (val < 0) val = 0;
        if (val > RANGE_MAX) val = RANGE_MAX;
        pick = $urandom_range(0, 99);
        if (pick < 80) c = c + 1'b1;
        else if (pick < 88) c = c;
        else if (pick < 96) c = c + COL_W'($urandom_range(2, 30));
        else c = COL_W'($urandom);
      end
      send_point(RANGE_W'(val), c, k == len - 1);
    end
  endtask

  // result side: check each taken word, then pick ready for the next edge
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        tracker.match_result(result_ch.point_index, result_ch.curvature, result_ch.interior,
                             result_ch.picked, result_ch.last_result);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !(recv_idle && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : main_flow
    int scan_no;
    int len;
    int random_start;
    tracker = new();
    rst <= 1'b1;
    point_ch.valid <= 1'b0;
    point_ch.range_mm <= '0;
    point_ch.column <= '0;
    point_ch.last_point <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SENSOR_MODE;
    cfg_wdata <= '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_requests = 0;
    points_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short scan of one point, all range and column bits set, reset settings
    send_point(RANGE_W'(RANGE_MAX), COL_W'(COL_MAX), 1'b1);

    // 12-point scan: a zero-range center among full ranges gives the largest
    // curvature, a jump that marks a wide run and a parallel beam point
    for (int k = 0; k < DEPTH; k++)
      send_point((k == 5) ? '0 : RANGE_W'(RANGE_MAX), COL_W'(COL_MAX - 11 + k), k == DEPTH - 1);
    settle_block();

    // mode change inside a scan: spinning for the first points, then solid-state
    for (int k = 0; k < 7; k++) send_point(RANGE_W'(4000 + 10 * k), COL_W'(100 + k), 1'b0);
    settle_block();
    write_reg(REG_SENSOR_MODE, 16'd1);
    write_reg(UNUSED_REG_LO + 3'd2, 16'hFFFF);
    cfg_we <= 1'b0;
    for (int k = 7; k < 13; k++) send_point(RANGE_W'(500 + 3 * k), COL_W'(100 + k), k == 12);
    settle_block();

    // random scans, settings changed between them only when the block is idle
    random_start = points_sent;
    scan_no = 0;
    while (scan_no < 6 || points_sent - random_start < RANDOM_POINTS) begin
      if (scan_no == 0 || scan_no == 3 || $urandom_range(0, 2) == 0) begin
        settle_block();
        set_config((scan_no == 0) ? 1 : (scan_no == 3) ? 2 : 0);
      end
      // a stretch with no idling at all on either side
      send_idle = !(scan_no >= 2 && scan_no < 5);
      recv_idle = send_idle;
      len = $urandom_range(0, 9);
      if (len < 7) len = $urandom_range(12, 40);
      else if (len < 9) len = $urandom_range(1, 11);
      else len = $urandom_range(41, 80);
      // receiver holds off while points keep coming, so the block backs up
      if (scan_no == 5) begin
        send_idle = 1'b0;
        len = 48;
        hold_requests++;
      end
      run_scan(len, $urandom_range(0, 99) < 15);
      scan_no++;
    end

    settle_block();
    tracker.close_out();
    if (tracker.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
